[hdl/vca_pkg.sv]
// ============================================================================
// vca_pkg
// Shared types, codes and constants of the voice channel allocator.
// ============================================================================
package vca_pkg;

    // Default table depth
    localparam int DEF_NUM_CHANNELS = 32;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int ENTITY_W  = 10;
    localparam int SUB_W     = 4;
    localparam int LENGTH_W  = 24;
    localparam int NOW_W     = 31;
    localparam int REL_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int CHAN_W    = 5;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 6;
    localparam int CFG_DW    = 10;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 8;

    // Reset values of the configuration registers
    localparam logic [COUNT_W-1:0]  RST_CHANNEL_COUNT = COUNT_W'(32);
    localparam logic [ENTITY_W-1:0] RST_PLAYER_ENTITY = ENTITY_W'(1);

    // Initial bound of the remaining-time search
    localparam logic [TIME_W-1:0] LIFE_BOUND = 32'h7fff_ffff;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_CHANNEL_COUNT = 1'b0,
        CFG_PLAYER_ENTITY = 1'b1
    } t_cfg_idx;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ISSUE   = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_SPARE   = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ASSIGNED = 2'd0,
        ST_NONE     = 2'd1,
        ST_NEG_SUB  = 2'd2,
        ST_DONE     = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_WRITE = 2'd2,
        S_DONE  = 2'd3
    } t_state;

    // One table entry held in memory
    typedef struct packed {
        logic [ENTITY_W-1:0] entity;
        logic [SUB_W-1:0]    sub;
        logic [TIME_W-1:0]   end_time;
    } t_chan;

    // Table control strobes
    typedef struct packed {
        logic clear;
        logic rel_we;
        logic wr_en;
    } t_tbl_ctl;

    // Scan control strobes
    typedef struct packed {
        logic start;
        logic cmp_vld;
        logic cmp_last;
    } t_scan_ctl;

    // Scan status
    typedef struct packed {
        logic found;
        logic stop;
    } t_scan_res;

endpackage

[hdl/voice_channel_allocator.sv]
// ============================================================================
// voice_channel_allocator
// Assigns sound issue requests to playback channels, reusing a matching
// subchannel or stealing the channel closest to its end; clears or releases
// channels on the other request kinds.
// ============================================================================
//
//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tuser: kind; tdata: entity, subchannel,
//            |           |   sound_length, now, release_index
//  m_axis    | out       | tuser: status; tdata: channel, stole_active
//  cfg       | in        | index 0 channel_count, index 1 player_entity
//
//  An issue request scans count = min(channel_count, NUM_CHANNELS) entries:
//  the table memory gives one entry per cycle on its single read port, and a
//  subchannel hit ends the scan early. Clear, release, negative subchannel and
//  spare kinds skip the scan. A new request is taken while the previous result
//  waits in the output register; a stalled output holds the sequencer in its
//  done state. Reset empties the table at once.
//
module voice_channel_allocator
    import vca_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [9:0] entity, [13:10] subchannel, [37:14] sound_length,
    // [68:38] now, [73:69] release_index, [79:74] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]     s_axis_tuser,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [4:0] channel, [5] stole_active, [7:6] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]   m_axis_tuser,
    // Configuration writes
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_addr,
    input  logic [CFG_DW-1:0]     i_cfg_wdata
);

    localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_channel_count;
    logic [ENTITY_W-1:0] r_player;

    // Request fields
    logic [ENTITY_W-1:0] r_entity;
    logic [SUB_W-1:0]    r_sub;
    logic [LENGTH_W-1:0] r_length;
    logic [NOW_W-1:0]    r_now;
    logic [CW-1:0]       r_last_idx;

    // Scan pipeline
    logic [CW-1:0]       r_addr;
    logic                r_issue_done;
    logic                r_cmp_vld;
    logic [CW-1:0]       r_cmp_idx;
    logic                r_cmp_last;

    // Pending result and output register
    t_status             r_res_status;
    logic [CHAN_W-1:0]   r_res_chan;
    logic                r_res_stole;
    logic                r_m_valid;
    t_status             r_m_status;
    logic [CHAN_W-1:0]   r_m_chan;
    logic                r_m_stole;

    logic                w_accept;
    t_kind               w_kind;
    logic [CNT_W-1:0]    w_count;
    logic [REL_W-1:0]    w_rel;
    logic                w_out_free;
    logic                w_load_out;
    t_tbl_ctl            w_tbl_ctl;
    t_scan_ctl           w_scan_ctl;
    t_scan_res           w_scan_res;
    t_chan               w_wr_chan;
    t_chan               w_rd_chan;
    logic                w_rd_active;
    logic [NUM_CHANNELS-1:0] w_active_vec;
    logic [CW-1:0]       w_chosen;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_kind     = t_kind'(s_axis_tuser);
    assign w_rel      = s_axis_tdata[73:69];
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_count    = (int'(r_channel_count) > NUM_CHANNELS) ?
                        CNT_W'(NUM_CHANNELS) : CNT_W'(r_channel_count);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= RST_CHANNEL_COUNT;
            r_player        <= RST_PLAYER_ENTITY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_wdata[COUNT_W-1:0];
                CFG_PLAYER_ENTITY: r_player        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes
    always_comb begin
        n_state             = r_state;
        s_axis_tready       = 1'b0;
        w_load_out          = 1'b0;
        w_tbl_ctl           = '0;
        w_scan_ctl.start    = 1'b0;
        w_scan_ctl.cmp_vld  = 1'b0;
        w_scan_ctl.cmp_last = r_cmp_last;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    w_scan_ctl.start = 1'b1;
                    case (w_kind)
                        KIND_CLEAR: begin
                            w_tbl_ctl.clear = 1'b1;
                            n_state         = S_DONE;
                        end
                        KIND_RELEASE: begin
                            w_tbl_ctl.rel_we = int'(w_rel) < NUM_CHANNELS;
                            n_state          = S_DONE;
                        end
                        KIND_ISSUE: begin
                            n_state = (s_axis_tdata[13] || w_count == '0) ? S_DONE : S_SCAN;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                w_scan_ctl.cmp_vld = r_cmp_vld;
                if (w_scan_res.stop) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                w_tbl_ctl.wr_en = w_scan_res.found;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Capture request and step the read address
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_entity   <= s_axis_tdata[9:0];
            r_sub      <= s_axis_tdata[13:10];
            r_length   <= s_axis_tdata[37:14];
            r_now      <= s_axis_tdata[68:38];
            r_last_idx <= CW'(w_count - CNT_W'(1));
            r_addr     <= '0;
        end else if (r_state == S_SCAN && r_addr != r_last_idx) begin
            r_addr <= r_addr + CW'(1);
        end
        r_cmp_idx  <= r_addr;
        r_cmp_last <= (r_addr == r_last_idx);
    end

    // Track issued reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_accept) begin
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == S_SCAN) && !r_issue_done && !w_scan_res.stop;
            if (r_state == S_SCAN && r_addr == r_last_idx) begin
                r_issue_done <= 1'b1;
            end
        end
    end

    // Prepare result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_chan  <= '0;
            r_res_stole <= 1'b0;
            if (w_kind != KIND_ISSUE) begin
                r_res_status <= ST_DONE;
            end else if (s_axis_tdata[13]) begin
                r_res_status <= ST_NEG_SUB;
            end else begin
                r_res_status <= ST_NONE;
            end
        end else if (r_state == S_WRITE && w_scan_res.found) begin
            r_res_status <= ST_ASSIGNED;
            r_res_chan   <= CHAN_W'(w_chosen);
            r_res_stole  <= w_active_vec[w_chosen];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_m_status <= r_res_status;
            r_m_chan   <= r_res_chan;
            r_m_stole  <= r_res_stole;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {2'b00, r_m_stole, r_m_chan};

    // New entry for the chosen channel
    assign w_wr_chan.entity   = r_entity;
    assign w_wr_chan.sub      = r_sub;
    assign w_wr_chan.end_time = {1'b0, r_now} + TIME_W'(r_length);

    vca_table #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_tbl_ctl),
        .i_rel_idx    (CW'(w_rel)),
        .i_wr_idx     (w_chosen),
        .i_wr_chan    (w_wr_chan),
        .i_rd_idx     (r_addr),
        .o_rd_chan    (w_rd_chan),
        .o_rd_active  (w_rd_active),
        .o_active_vec (w_active_vec)
    );

    vca_scan #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_scan_ctl),
        .i_idx        (r_cmp_idx),
        .i_chan       (w_rd_chan),
        .i_active     (w_rd_active),
        .i_req_entity (r_entity),
        .i_req_sub    (r_sub),
        .i_req_now    (r_now),
        .i_player     (r_player),
        .o_res        (w_scan_res),
        .o_chosen     (w_chosen)
    );

    // A chosen channel is active after its write-back
    a_write_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && w_scan_res.found) |=> w_active_vec[$past(w_chosen)])
        else $error("chosen channel not active after write-back");

    // Clear empties every active flag
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind == KIND_CLEAR) |=> (w_active_vec == '0))
        else $error("active flags remain after clear");

    // Only an assignment carries a channel or a steal flag
    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_ASSIGNED) |-> (m_axis_tdata == '0))
        else $error("non-assigned result carries channel data");

endmodule

[hdl/vca_table.sv]
// ============================================================================
// vca_table
// Channel table: entry memory with registered read, plus written and active
// flags per channel in flip-flops that reset and clear empty at once.
// ============================================================================
module vca_table
    import vca_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_tbl_ctl                i_ctl,
    input  logic [CW-1:0]           i_rel_idx,
    input  logic [CW-1:0]           i_wr_idx,
    input  t_chan                   i_wr_chan,
    input  logic [CW-1:0]           i_rd_idx,
    output t_chan                   o_rd_chan,
    output logic                    o_rd_active,
    output logic [NUM_CHANNELS-1:0] o_active_vec
);

    t_chan                   mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_valid;
    logic [NUM_CHANNELS-1:0] r_active;
    t_chan                   r_rd_chan;
    logic                    r_rd_valid;
    logic                    r_rd_active;

    // Write entry memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_idx] <= i_wr_chan;
        end
    end

    // Read entry memory, registered
    always_ff @(posedge i_clk) begin
        r_rd_chan <= mem[i_rd_idx];
    end

    // Track written and active flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid  <= '0;
            r_active <= '0;
        end else begin
            if (i_ctl.rel_we) begin
                r_active[i_rel_idx] <= 1'b0;
            end
            if (i_ctl.wr_en) begin
                r_valid[i_wr_idx]  <= 1'b1;
                r_active[i_wr_idx] <= 1'b1;
            end
        end
    end

    // Register flags alongside the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_rd_active <= 1'b0;
        end else begin
            r_rd_valid  <= r_valid[i_rd_idx];
            r_rd_active <= r_active[i_rd_idx];
        end
    end

    // Unwritten entries read as zero
    assign o_rd_chan    = r_rd_valid ? r_rd_chan : '0;
    assign o_rd_active  = r_rd_active;
    assign o_active_vec = r_active;

endmodule

[hdl/vca_scan.sv]
// ============================================================================
// vca_scan
// Victim search: compares one table entry per cycle, while the compare strobe
// is set, against the request and keeps the best candidate, stopping on a subchannel hit or the last entry.
// ============================================================================
module vca_scan
    import vca_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_scan_ctl           i_ctl,
    input  logic [CW-1:0]       i_idx,
    input  t_chan               i_chan,
    input  logic                i_active,
    input  logic [ENTITY_W-1:0] i_req_entity,
    input  logic [SUB_W-1:0]    i_req_sub,
    input  logic [NOW_W-1:0]    i_req_now,
    input  logic [ENTITY_W-1:0] i_player,
    output t_scan_res           o_res,
    output logic [CW-1:0]       o_chosen
);

    logic [TIME_W-1:0] r_best;
    logic [CW-1:0]     r_chosen;
    logic              r_found;
    logic [TIME_W-1:0] w_life;
    logic              w_hit;
    logic              w_skip;
    logic              w_better;

    // Compare current entry
    always_comb begin
        w_life   = i_chan.end_time - {1'b0, i_req_now};
        w_hit    = (i_req_sub != '0) && (i_chan.entity == i_req_entity) &&
                   (i_chan.sub == i_req_sub);
        w_skip   = (i_chan.entity == i_player) && (i_req_entity != i_player) && i_active;
        w_better = $signed(w_life) < $signed(r_best);
    end

    // Hold best candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_found  <= 1'b0;
            r_best   <= LIFE_BOUND;
            r_chosen <= '0;
        end else if (i_ctl.cmp_vld) begin
            if (w_hit) begin
                r_found  <= 1'b1;
                r_chosen <= i_idx;
            end else if (!w_skip && w_better) begin
                r_found  <= 1'b1;
                r_best   <= w_life;
                r_chosen <= i_idx;
            end
        end
    end

    assign o_res.found = r_found;
    assign o_res.stop  = i_ctl.cmp_vld && (w_hit || i_ctl.cmp_last);
    assign o_chosen    = r_chosen;

endmodule
